@@ hw/rtl/gic_pkg.sv @@
`default_nettype none

package gic_pkg;

  localparam int BANK_COUNT = 4;
  localparam int BANK_W     = $clog2(BANK_COUNT);
  localparam int PINS       = 32;

  localparam logic [7:0]  CAP_OFFSET = 8'hA0;
  localparam logic [31:0] CAP_VALUE  = 32'h0001_0000 | (32'(BANK_COUNT) << 8)
                                     | 32'(BANK_COUNT * PINS);

  // access kind carried in the cmd field
  localparam logic ACC_READ  = 1'b0;
  localparam logic ACC_WRITE = 1'b1;

  // register group codes, offset bits 7:4
  localparam logic [3:0] GRP_OUT  = 4'h0;
  localparam logic [3:0] GRP_SET  = 4'h1;
  localparam logic [3:0] GRP_CLR  = 4'h2;
  localparam logic [3:0] GRP_IN   = 4'h3;
  localparam logic [3:0] GRP_DIR  = 4'h4;
  localparam logic [3:0] GRP_IE   = 4'h5;
  localparam logic [3:0] GRP_TRIG = 4'h6;
  localparam logic [3:0] GRP_POL  = 4'h7;
  localparam logic [3:0] GRP_STAT = 4'h8;
  localparam logic [3:0] GRP_LOOP = 4'h9;

  typedef logic [PINS-1:0] word_t;
  typedef word_t [BANK_COUNT-1:0] bank_words_t;

  typedef struct packed {
    bank_words_t outw;
    bank_words_t dirw;
    bank_words_t iew;
    bank_words_t edgew;
    bank_words_t polw;
    bank_words_t statw;
    bank_words_t loopw;
  } gpio_state_t;

  typedef struct packed {
    logic       cmd;
    logic [7:0] offset;
    logic [2:0] nbytes;
    word_t      wdata;
  } acc_t;

  typedef struct packed {
    word_t rdata;
    logic  err;
    logic  irq;
  } rsp_t;

  function automatic word_t size_mask(input logic [2:0] n);
    word_t m;
    case (n)
      3'd0:    m = '0;
      3'd1:    m = 32'h0000_00FF;
      3'd2:    m = 32'h0000_FFFF;
      3'd3:    m = 32'h00FF_FFFF;
      default: m = '1;
    endcase
    return m;
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/gic_req_if.sv @@
`default_nettype none

interface gic_req_if;
  logic        valid;
  logic        ready;
  logic        cmd;
  logic [7:0]  offset;
  logic [2:0]  access_bytes;
  logic [31:0] write_data;

  modport source (output valid, cmd, offset, access_bytes, write_data, input ready);
  modport sink   (input valid, cmd, offset, access_bytes, write_data, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/gic_rsp_if.sv @@
`default_nettype none

interface gic_rsp_if;
  logic        valid;
  logic        ready;
  logic [31:0] read_data;
  logic        bus_error;
  logic        irq_level;

  modport source (output valid, read_data, bus_error, irq_level, input ready);
  modport sink   (input valid, read_data, bus_error, irq_level, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/gic_irq.sv @@
`default_nettype none

module gic_irq (
  input  gic_pkg::gpio_state_t st,
  output logic                 irq
);
  import gic_pkg::*;

  logic [BANK_COUNT-1:0] hit;

  always_comb begin
    for (int k = 0; k < BANK_COUNT; k++) begin
      // edge status, level high, level low; only loopback pins drive levels
      hit[k] = |((st.statw[k] & st.edgew[k] & st.iew[k])
               | (~st.edgew[k] & st.polw[k] & st.iew[k] & st.outw[k] & st.loopw[k])
               | (~st.edgew[k] & ~st.polw[k] & st.iew[k] & st.loopw[k]
                  & ~(st.outw[k] & st.loopw[k])));
    end
    irq = |hit;
  end

endmodule

`default_nettype wire

@@ hw/rtl/gic_regs.sv @@
`default_nettype none

module gic_regs (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          we,
  input  gic_pkg::acc_t acc,
  output gic_pkg::rsp_t rsp
);
  import gic_pkg::*;

  gpio_state_t       state_r;
  gpio_state_t       state_nxt;
  logic [BANK_W-1:0] bank;
  logic [3:0]        grp;
  logic              err;
  word_t             mask;
  word_t             wval;
  word_t             out_new;
  word_t             out_old;
  word_t             armed;
  word_t             rd_raw;
  logic              wr_out;
  logic              irq_nxt;

  always_comb begin
    bank      = acc.offset[3:2];
    grp       = acc.offset[7:4];
    err       = acc.offset > CAP_OFFSET;
    mask      = size_mask(acc.nbytes);
    wval      = acc.wdata & mask;
    state_nxt = state_r;
    out_old   = state_r.outw[bank];
    out_new   = out_old;
    wr_out    = 1'b0;

    if (acc.cmd == ACC_WRITE && !err && acc.offset != CAP_OFFSET) begin
      unique case (grp)
        GRP_OUT:  begin out_new = wval;            wr_out = 1'b1; end
        GRP_SET:  begin out_new = out_old | wval;  wr_out = 1'b1; end
        GRP_CLR:  begin out_new = out_old & ~wval; wr_out = 1'b1; end
        GRP_DIR:  state_nxt.dirw[bank]  = wval;
        GRP_IE:   state_nxt.iew[bank]   = wval;
        GRP_TRIG: state_nxt.edgew[bank] = wval;
        GRP_POL:  state_nxt.polw[bank]  = wval;
        GRP_STAT: state_nxt.statw[bank] = state_r.statw[bank] & ~wval;
        GRP_LOOP: state_nxt.loopw[bank] = wval;
        default:  ;
      endcase
    end

    // latch edges of the selected polarity on armed loopback pins when the output word changes
    armed = state_r.loopw[bank] & state_r.edgew[bank] & state_r.iew[bank];
    if (wr_out) begin
      state_nxt.outw[bank]  = out_new;
      state_nxt.statw[bank] = state_r.statw[bank]
                            | (((out_new & ~out_old & state_r.polw[bank])
                              | (~out_new & out_old & ~state_r.polw[bank])) & armed);
    end

    unique case (grp) inside
      GRP_OUT, GRP_SET, GRP_CLR: rd_raw = state_r.outw[bank];
      GRP_IN:   rd_raw = state_r.outw[bank] & state_r.loopw[bank];
      GRP_DIR:  rd_raw = state_r.dirw[bank];
      GRP_IE:   rd_raw = state_r.iew[bank];
      GRP_TRIG: rd_raw = state_r.edgew[bank];
      GRP_POL:  rd_raw = state_r.polw[bank];
      GRP_STAT: rd_raw = state_r.statw[bank];
      GRP_LOOP: rd_raw = state_r.loopw[bank];
      default:  rd_raw = '0;
    endcase

    if (acc.cmd == ACC_READ && !err) begin
      rsp.rdata = ((acc.offset == CAP_OFFSET) ? CAP_VALUE : rd_raw) & mask;
    end else begin
      rsp.rdata = '0;
    end
    rsp.err = err;
    rsp.irq = irq_nxt;
  end

  gic_irq u_irq (
    .st  (state_nxt),
    .irq (irq_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '0;
    end else if (we) begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/gpio_interrupt_controller_unit.sv @@
// GPIO register block with four banks of 32 pins and edge/level interrupts.
// Each request beat is one bus read or write; it is registered, applied to
// the bank registers as it leaves the request stage, and its response
// (read data, bus error, interrupt level after the access) is held in an
// output register. One access per cycle is sustained while responses are
// taken; a new request is accepted while its predecessor advances.
// Back-pressure on the response side stalls the request side only
// once both the request stage and the response register are occupied.
`default_nettype none

module gpio_interrupt_controller_unit (
  input logic      clk,
  input logic      rst_n,
  gic_req_if.sink  in_ch,
  gic_rsp_if.source out_ch
);
  import gic_pkg::*;

  logic s1_valid_r;
  logic s1_valid_nxt;
  acc_t s1_acc_r;
  logic out_valid_r;
  logic out_valid_nxt;
  rsp_t out_rsp_r;
  rsp_t rsp;
  logic adv;
  logic in_fire;

  assign adv          = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready  = !s1_valid_r || adv;
  assign in_fire      = in_ch.valid && in_ch.ready;

  always_comb begin
    s1_valid_nxt = in_fire ? 1'b1 : (adv ? 1'b0 : s1_valid_r);
    if (adv) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  gic_regs u_regs (
    .clk   (clk),
    .rst_n (rst_n),
    .we    (adv),
    .acc   (s1_acc_r),
    .rsp   (rsp)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload: capture request beat, hold response until taken
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_acc_r.cmd    <= in_ch.cmd;
      s1_acc_r.offset <= in_ch.offset;
      s1_acc_r.nbytes <= in_ch.access_bytes;
      s1_acc_r.wdata  <= in_ch.write_data;
    end
    if (adv) begin
      out_rsp_r <= rsp;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.read_data = out_rsp_r.rdata;
  assign out_ch.bus_error = out_rsp_r.err;
  assign out_ch.irq_level = out_rsp_r.irq;

endmodule

`default_nettype wire

@@ hw/rtl/gic_checker.sv @@
`default_nettype none

module gic_checker (
  input wire        clk,
  input wire        rst_n,
  input wire        in_ready,
  input wire        out_valid,
  input wire        out_ready,
  input wire [31:0] out_read_data,
  input wire        out_bus_error,
  input wire        out_irq_level
);

  // a stalled response beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_read_data)
      && $stable(out_bus_error) && $stable(out_irq_level))
    else $error("response changed while stalled");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_bus_error |-> out_read_data == 32'd0)
    else $error("bus error with nonzero read data");

  // requests stall only behind a full, stalled response register
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready)
    else $error("request side stalled without response back-pressure");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("response valid right after reset");

endmodule

bind gpio_interrupt_controller_unit gic_checker u_chk (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_ready      (in_ch.ready),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .out_read_data (out_ch.read_data),
  .out_bus_error (out_ch.bus_error),
  .out_irq_level (out_ch.irq_level)
);

`default_nettype wire
